// ===== hdl/s2a_pkg.sv =====
// ----------------------------------------------------------------------------
// s2a_pkg: shared types and encodings for the a64 translator
// opcodes of the hash program, aarch64 base opcodes and helper functions
// ----------------------------------------------------------------------------
package s2a_pkg;

  typedef enum logic [3:0] {
    OPC_SUB    = 4'd0,
    OPC_XOR    = 4'd1,
    OPC_ADDSH  = 4'd2,
    OPC_MUL    = 4'd3,
    OPC_ROR    = 4'd4,
    OPC_ADDIMM = 4'd5,
    OPC_XORIMM = 4'd6,
    OPC_UMULH  = 4'd7,
    OPC_SMULH  = 4'd8,
    OPC_MULRCP = 4'd9
  } opcode_e;

  localparam logic [31:0] A64_SUB     = 32'hCB000000;
  localparam logic [31:0] A64_EOR     = 32'hCA000000;
  localparam logic [31:0] A64_ADD     = 32'h8B000000;
  localparam logic [31:0] A64_MUL     = 32'h9B007C00;
  localparam logic [31:0] A64_UMULH   = 32'h9BC07C00;
  localparam logic [31:0] A64_SMULH   = 32'h9B407C00;
  localparam logic [31:0] A64_MOVZ    = 32'hD2800000;
  localparam logic [31:0] A64_MOVN    = 32'h92800000;
  localparam logic [31:0] A64_MOVK    = 32'hF2800000;
  localparam logic [31:0] A64_ADDI_LO = 32'h91000000;
  localparam logic [31:0] A64_ADDI_HI = 32'h91400000;
  localparam logic [31:0] A64_LDRLIT  = 32'h58000000;
  localparam logic [31:0] A64_EXTR    = 32'h93C00000;

  localparam logic [31:0] HW_SHIFT16  = 32'h00200000;
  localparam int unsigned IN_W        = 104;
  localparam int unsigned OUT_W       = 56;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic        two;
  } imm_load_t;

  // three-operand register form rd = rd op rm
  function automatic logic [31:0] enc_rrr(logic [31:0] base, logic [4:0] rd, logic [4:0] rm);
    enc_rrr = base | {27'd0, rd} | {22'd0, rd, 5'd0} | {11'd0, rm, 16'd0};
  endfunction

  // movz/movn/movk sequence for a 32-bit constant
  function automatic imm_load_t enc_load_imm(logic [4:0] rd, logic [31:0] imm);
    imm_load_t r;
    logic [15:0] upper;
    upper = imm[31] ? ~imm[31:16] : imm[31:16];
    r.w1  = A64_MOVK | {27'd0, rd} | {11'd0, imm[15:0], 5'd0};
    if (imm[31:16] == 16'd0) begin
      r.w0  = A64_MOVZ | {27'd0, rd} | {11'd0, imm[15:0], 5'd0};
      r.two = 1'b0;
    end else begin
      r.w0  = (imm[31] ? A64_MOVN : A64_MOVZ) | HW_SHIFT16 | {27'd0, rd}
              | {11'd0, upper, 5'd0};
      r.two = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/superscalar_to_a64_translator.sv =====
// ----------------------------------------------------------------------------
// superscalar_to_a64_translator: hash-program instruction to aarch64 words
//
// Slave stream takes one instruction per request (tdata, fields below).
// Master stream gives one 32-bit instruction word per request with the
// literal position after the item; tlast marks the final word of an item.
// An item is held in an input register and encoded there by short logic;
// a sequencer moves its one to three words, one per cycle while the
// output register is free, into the output register. The first word
// passes the input register and then the output register; unknown
// opcodes emit nothing and are dropped. The next item is accepted in
// the cycle its predecessor's last word moves to the output register, so
// items follow back to back. When the receiver stalls the output register
// holds its word and the input register fills, after which s_axis_tready
// falls. Reset empties both registers; no word is pending after reset.
// ----------------------------------------------------------------------------
module superscalar_to_a64_translator
  import s2a_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode, dst_reg, src_reg, scratch_reg, immediate, shift_amount,
  // code_pos, literal_pos, zero pad
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // instr_word, next_literal_pos
  output logic [OUT_W-1:0]  m_axis_tdata,
  output logic              m_axis_tlast
);

  logic        in_valid_q;
  logic [3:0]  opc_q;
  logic [4:0]  dst_q, src_q, tmp_q;
  logic [31:0] imm_q;
  logic [1:0]  sh_q;
  logic [23:0] cpos_q, lpos_q;
  logic [1:0]  idx_q, idx_d;

  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [23:0] out_lit_q;
  logic        out_last_q;

  logic [31:0] words [3];
  logic [1:0]  nwords;
  logic [23:0] nlit, ldiff;
  imm_load_t   ld;
  logic [11:0] lo12, hi12;
  logic        out_free, move, last_move, done, accept;

  always_comb begin
    words[0] = 32'd0;
    words[1] = 32'd0;
    words[2] = 32'd0;
    nwords   = 2'd0;
    nlit     = lpos_q;
    ldiff    = lpos_q - cpos_q;
    ld       = enc_load_imm(tmp_q, imm_q);
    lo12     = imm_q[11:0];
    hi12     = imm_q[23:12];
    unique case (opcode_e'(opc_q))
      OPC_SUB: begin
        words[0] = enc_rrr(A64_SUB, dst_q, src_q);
        nwords   = 2'd1;
      end
      OPC_XOR: begin
        words[0] = enc_rrr(A64_EOR, dst_q, src_q);
        nwords   = 2'd1;
      end
      OPC_ADDSH: begin
        words[0] = enc_rrr(A64_ADD, dst_q, src_q) | {20'd0, sh_q, 10'd0};
        nwords   = 2'd1;
      end
      OPC_MUL: begin
        words[0] = enc_rrr(A64_MUL, dst_q, src_q);
        nwords   = 2'd1;
      end
      OPC_UMULH: begin
        words[0] = enc_rrr(A64_UMULH, dst_q, src_q);
        nwords   = 2'd1;
      end
      OPC_SMULH: begin
        words[0] = enc_rrr(A64_SMULH, dst_q, src_q);
        nwords   = 2'd1;
      end
      OPC_ROR: begin
        words[0] = enc_rrr(A64_EXTR, dst_q, dst_q) | {16'd0, imm_q[5:0], 10'd0};
        nwords   = 2'd1;
      end
      OPC_ADDIMM: begin
        if (imm_q[31:24] == 8'd0) begin
          if (lo12 != 12'd0 && hi12 != 12'd0) begin
            words[0] = enc_rrr(A64_ADDI_LO, dst_q, 5'd0) | {10'd0, lo12, 10'd0};
            words[1] = enc_rrr(A64_ADDI_HI, dst_q, 5'd0) | {10'd0, hi12, 10'd0};
            nwords   = 2'd2;
          end else if (lo12 != 12'd0) begin
            words[0] = enc_rrr(A64_ADDI_LO, dst_q, 5'd0) | {10'd0, lo12, 10'd0};
            nwords   = 2'd1;
          end else begin
            words[0] = enc_rrr(A64_ADDI_HI, dst_q, 5'd0) | {10'd0, hi12, 10'd0};
            nwords   = 2'd1;
          end
        end else begin
          words[0] = ld.w0;
          if (ld.two) begin
            words[1] = ld.w1;
            words[2] = enc_rrr(A64_ADD, dst_q, tmp_q);
            nwords   = 2'd3;
          end else begin
            words[1] = enc_rrr(A64_ADD, dst_q, tmp_q);
            nwords   = 2'd2;
          end
        end
      end
      OPC_XORIMM: begin
        words[0] = ld.w0;
        if (ld.two) begin
          words[1] = ld.w1;
          words[2] = enc_rrr(A64_EOR, dst_q, tmp_q);
          nwords   = 2'd3;
        end else begin
          words[1] = enc_rrr(A64_EOR, dst_q, tmp_q);
          nwords   = 2'd2;
        end
      end
      OPC_MULRCP: begin
        words[0] = A64_LDRLIT | {27'd0, tmp_q} | {8'd0, ldiff[20:2], 5'd0};
        words[1] = enc_rrr(A64_MUL, dst_q, tmp_q);
        nwords   = 2'd2;
        nlit     = lpos_q + 24'd8;
      end
      default: begin
        nwords = 2'd0;
      end
    endcase
  end

  assign out_free  = !out_valid_q || m_axis_tready;
  assign move      = in_valid_q && (nwords != 2'd0) && out_free;
  assign last_move = move && (idx_q == nwords - 2'd1);
  assign done      = in_valid_q && ((nwords == 2'd0) || last_move);
  assign s_axis_tready = !in_valid_q || done;
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    idx_d = idx_q;
    if (done) begin
      idx_d = 2'd0;
    end else if (move) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (done) begin
        in_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opc_q  <= s_axis_tdata[3:0];
      dst_q  <= s_axis_tdata[8:4];
      src_q  <= s_axis_tdata[13:9];
      tmp_q  <= s_axis_tdata[18:14];
      imm_q  <= s_axis_tdata[50:19];
      sh_q   <= s_axis_tdata[52:51];
      cpos_q <= s_axis_tdata[76:53];
      lpos_q <= s_axis_tdata[100:77];
    end
    if (move) begin
      out_word_q <= words[idx_q];
      out_lit_q  <= nlit;
      out_last_q <= (idx_q == nwords - 2'd1);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_lit_q, out_word_q};
  assign m_axis_tlast  = out_last_q;

endmodule
